// ===== sv/length_framed_packet_deframer_defines.svh =====
`ifndef LENGTH_FRAMED_PACKET_DEFRAMER_DEFINES_SVH
`define LENGTH_FRAMED_PACKET_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define LFPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define LFPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lfpd_pkg.sv =====
package lfpd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_SYNC = 3'd1,
        PH_ID   = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_SUM  = 3'd5,
        PH_END  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_SYNC     = 2'd1,
        ERR_END      = 2'd2,
        ERR_CHECKSUM = 2'd3
    } t_err;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_BYTE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXEMPT_ID     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXEMPT_ENABLE = 3'd4;

    localparam logic [7:0] RST_START_BYTE    = 8'h55;
    localparam logic [7:0] RST_SYNC_BYTE     = 8'h02;
    localparam logic [7:0] RST_END_BYTE      = 8'h03;
    localparam logic [7:0] RST_EXEMPT_ID     = 8'h83;
    localparam logic       RST_EXEMPT_ENABLE = 1'b1;

    localparam int unsigned OUT_TDATA_W = 40;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] sync_byte;
        logic [7:0] end_byte;
        logic [7:0] exempt_id;
        logic       exempt_enable;
    } t_cfg;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] frame_id;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic [7:0] frame_len;
        logic       frame_good;
        t_err       error_code;
    } t_result;

endpackage

// ===== sv/length_framed_packet_deframer.sv =====
// Each payload or verdict word is registered into the output word register or the skid word.
// Throughput: one received byte per cycle while the skid word is empty (o_s_tready high).
// A two-word output buffer lets the slave side keep accepting while one word waits downstream.
// Reset (i_rst_n low at a clock edge) clears the frame state, empties the output buffer
// and restores the configuration registers to their defaults.
module length_framed_packet_deframer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [7:0]                           i_s_tdata,  // [7:0] rx_byte
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [7:0] frame_id, [15:8] data_byte, [23:16] data_index, [31:24] frame_len,
    // [32] frame_good, [34:33] error_code, [39:35] zero
    output logic [lfpd_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                 o_m_tuser,  // [0] result_kind
    input  logic                                 i_cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [7:0]                           i_cfg_data
);
    import lfpd_pkg::*;

    `include "length_framed_packet_deframer_defines.svh"

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte    <= RST_START_BYTE;
            r_cfg.sync_byte     <= RST_SYNC_BYTE;
            r_cfg.end_byte      <= RST_END_BYTE;
            r_cfg.exempt_id     <= RST_EXEMPT_ID;
            r_cfg.exempt_enable <= RST_EXEMPT_ENABLE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_BYTE:    r_cfg.start_byte    <= i_cfg_data;
                REG_SYNC_BYTE:     r_cfg.sync_byte     <= i_cfg_data;
                REG_END_BYTE:      r_cfg.end_byte      <= i_cfg_data;
                REG_EXEMPT_ID:     r_cfg.exempt_id     <= i_cfg_data;
                REG_EXEMPT_ENABLE: r_cfg.exempt_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    logic    in_accept;
    logic    emit;
    t_result result;

    assign in_accept = i_s_tvalid && o_s_tready;

    lfpd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_s_tdata),
        .i_cfg    (r_cfg),
        .o_emit   (emit),
        .o_result (result)
    );

    // Output word register plus a skid word; the slave side only stalls when both are full.
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    push;
    logic    pop;

    assign push = in_accept && emit;
    assign pop  = r_out_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (push) begin
                if (!r_out_valid || pop) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (pop) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            if (!r_out_valid || pop) begin
                r_out <= result;
            end else begin
                r_skid <= result;
            end
        end else if (pop && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_s_tready = !r_skid_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {5'd0, r_out.error_code, r_out.frame_good, r_out.frame_len,
                         r_out.data_index, r_out.data_byte, r_out.frame_id};

    `LFPD_ASSERT_NOW(a_skid_implies_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid word held while output register empty")
    `LFPD_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, !o_s_tready && i_m_tready, o_s_tready, "skid word not drained after downstream took a word")
    `LFPD_ASSERT_NOW(a_good_no_error, i_clk, i_rst_n, r_out_valid && r_out.frame_good, r_out.kind == KIND_VERDICT && r_out.error_code == ERR_NONE, "good flag on a word that is not a clean verdict")
    `LFPD_ASSERT_NOW(a_payload_clean, i_clk, i_rst_n, r_out_valid && r_out.kind == KIND_PAYLOAD, r_out.error_code == ERR_NONE, "payload word carries an error code")

endmodule

// ===== sv/lfpd_parser.sv =====
module lfpd_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  lfpd_pkg::t_cfg  i_cfg,
    output logic            o_emit,
    output lfpd_pkg::t_result o_result
);
    import lfpd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_id, n_id;
    logic [7:0] r_len, n_len;
    logic [7:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic       r_sync_ok, n_sync_ok;
    logic [7:0] r_rx_sum, n_rx_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_id      <= '0;
            r_len     <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_sync_ok <= 1'b0;
            r_rx_sum  <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_id      <= n_id;
            r_len     <= n_len;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_sync_ok <= n_sync_ok;
            r_rx_sum  <= n_rx_sum;
        end
    end

    logic end_ok;
    logic sum_ok;
    logic exempt;
    t_err verdict_err;
    logic last_payload;

    always_comb begin
        end_ok = (i_byte == i_cfg.end_byte);
        sum_ok = (r_rx_sum == r_sum);
        exempt = i_cfg.exempt_enable && (r_id == i_cfg.exempt_id);
        if (!r_sync_ok) begin
            verdict_err = ERR_SYNC;
        end else if (!end_ok) begin
            verdict_err = ERR_END;
        end else if (!sum_ok && !exempt) begin
            verdict_err = ERR_CHECKSUM;
        end else begin
            verdict_err = ERR_NONE;
        end
        last_payload = ({1'b0, r_count} + 9'd1) >= {1'b0, r_len};
    end

    always_comb begin
        n_phase   = r_phase;
        n_id      = r_id;
        n_len     = r_len;
        n_count   = r_count;
        n_sum     = r_sum;
        n_sync_ok = r_sync_ok;
        n_rx_sum  = r_rx_sum;
        o_emit    = 1'b0;

        o_result.kind       = KIND_PAYLOAD;
        o_result.frame_id   = r_id;
        o_result.data_byte  = i_byte;
        o_result.data_index = r_count;
        o_result.frame_len  = r_len;
        o_result.frame_good = 1'b0;
        o_result.error_code = ERR_NONE;

        case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_cfg.start_byte) begin
                    n_phase = PH_SYNC;
                end
            end
            PH_SYNC: begin
                n_sync_ok = (i_byte == i_cfg.sync_byte);
                n_phase   = PH_ID;
            end
            PH_ID: begin
                n_id    = i_byte;
                n_sum   = i_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len   = i_byte;
                n_sum   = r_sum + i_byte;
                n_count = '0;
                n_phase = (i_byte == 8'd0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
                o_emit  = 1'b1;
                n_sum   = r_sum + i_byte;
                n_count = r_count + 8'd1;
                if (last_payload) begin
                    n_phase = PH_SUM;
                end
            end
            PH_SUM: begin
                n_rx_sum = i_byte;
                n_phase  = PH_END;
            end
            PH_END: begin
                o_emit              = 1'b1;
                o_result.kind       = KIND_VERDICT;
                o_result.data_byte  = '0;
                o_result.data_index = '0;
                o_result.frame_good = (verdict_err == ERR_NONE);
                o_result.error_code = verdict_err;
                // A rejected frame whose end slot carries the start byte reopens at once.
                if ((verdict_err != ERR_NONE) && (i_byte == i_cfg.start_byte)) begin
                    n_phase = PH_SYNC;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

endmodule
